/* sv/ttf_pkg.sv */
// Shared types, constants and lane helper for the triangle tangent frame unit.
package ttf_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int WORD_W          = 3 * COMPONENT_WIDTH;
    localparam int EFF_W           = (COMPONENT_WIDTH > 16) ? 16 : COMPONENT_WIDTH;

    // Normalizer depth: restoring divide then bit-serial square root
    localparam int DIV_STEPS   = 31;
    localparam int ROOT_STEPS  = 16;
    localparam int NORM_STAGES = DIV_STEPS + ROOT_STEPS;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DET = 2'd1;
    localparam logic [1:0] STATUS_ZERO_LEN = 2'd2;

    typedef struct packed {
        logic [31:0] corner_c_uv;
        logic [31:0] corner_b_uv;
        logic [31:0] corner_a_uv;
        logic [47:0] corner_c_position;
        logic [47:0] corner_b_position;
        logic [47:0] corner_a_position;
    } ttf_item_t;

    typedef struct packed {
        logic [1:0]         frame_status;
        logic signed [15:0] bitangent_z;
        logic signed [15:0] bitangent_y;
        logic signed [15:0] bitangent_x;
        logic signed [15:0] tangent_z;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_x;
    } ttf_result_t;

    // Lane k of a word; wide lanes keep only their top 16 bits.
    function automatic logic signed [16:0] lane_get(input logic [WORD_W-1:0] word,
                                                    input int k,
                                                    input logic is_signed);
        logic [COMPONENT_WIDTH-1:0] bits;
        logic [EFF_W-1:0]           eff;
        bits = word[k*COMPONENT_WIDTH +: COMPONENT_WIDTH];
        eff  = bits[COMPONENT_WIDTH-1 -: EFF_W];
        if (is_signed)
            return 17'($signed(eff));
        else
            return $signed({{(17-EFF_W){1'b0}}, eff});
    endfunction

endpackage

/* sv/ttf_norm.sv */
// One component normalizer: floor(sq*2^30/s2) by restoring divide, isqrt, round.
module ttf_norm (
    input  logic        clk,
    input  logic [31:0] sq,
    input  logic [33:0] s2,
    output logic [14:0] root
);

    localparam int DS = ttf_pkg::DIV_STEPS;
    localparam int RS = ttf_pkg::ROOT_STEPS;

    logic [34:0]   rem_reg [DS-1];
    logic [33:0]   den_reg [DS-1];
    logic [DS-1:0] quo_reg [DS];

    logic [DS-1:0] n_reg   [RS-1];
    logic [DS-1:0] acc_reg [RS-1];
    logic [15:0]   rt_reg  [RS];

    genvar j, i;

    // divide: one quotient bit per stage, MSB first
    for (j = 0; j < DS; j++)
    begin : g_div
        logic [34:0]   rem_in;
        logic [33:0]   den_in;
        logic [DS-1:0] quo_in;
        logic [34:0]   diff;
        logic          ge;

        if (j == 0)
        begin : g_first
            assign rem_in = 35'(sq);
            assign den_in = s2;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = {rem_reg[j-1][33:0], 1'b0};
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign ge   = rem_in >= 35'(den_in);
        assign diff = rem_in - 35'(den_in);

        always_ff @(posedge clk)
        begin
            quo_reg[j] <= {quo_in[DS-2:0], ge};
        end

        if (j < DS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[j] <= ge ? diff : rem_in;
                den_reg[j] <= den_in;
            end
        end
    end

    // square root: one root bit per stage, running square kept alongside
    for (i = 0; i < RS; i++)
    begin : g_root
        logic [DS-1:0] n_in;
        logic [DS-1:0] acc_in;
        logic [15:0]   rt_in;
        logic [32:0]   trial;
        logic          ok;

        if (i == 0)
        begin : g_first
            assign n_in   = quo_reg[DS-1];
            assign acc_in = '0;
            assign rt_in  = '0;
        end
        else
        begin : g_next
            assign n_in   = n_reg[i-1];
            assign acc_in = acc_reg[i-1];
            assign rt_in  = rt_reg[i-1];
        end

        assign trial = 33'(acc_in) + (33'(rt_in) << (RS - i))
                     + (33'(1) << (2 * (RS - 1 - i)));
        assign ok    = trial <= 33'(n_in);

        always_ff @(posedge clk)
        begin
            rt_reg[i] <= ok ? (rt_in | (16'(1) << (RS - 1 - i))) : rt_in;
        end

        if (i < RS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                n_reg[i]   <= n_in;
                acc_reg[i] <= ok ? DS'(trial) : acc_in;
            end
        end
    end

    // round half up on the doubled scale
    assign root = 15'((17'(rt_reg[RS-1]) + 17'd1) >> 1);

endmodule

/* sv/triangle_tangent_frame_unit.sv */
// Top level of the triangle tangent frame unit: deltas, cross terms, normalization.
//
// Usage:
//   Input channel: a triangle word (three signed corner positions, three
//   unsigned UVs) is taken at a rising edge where start is high and busy is
//   low. busy never rises, so one triangle may enter every cycle.
//   Output channel: done is high for one cycle with frame_word holding the
//   unit tangent, unit bitangent (signed Q1.14) and frame_status.
//   Throughput: one word per cycle, set by the fully pipelined
//   datapath: 9 arithmetic stages, then per component a 31-stage restoring
//   divider and a 16-stage square root, then the output register.
//   Words leave in the order they entered.
//   Reset (rst_n low, async) drops every word in flight; done stays low
//   until new words come through. The receiver cannot stall, so nothing is
//   held back on the output side.
//   Status: zero UV determinant or a zero-length tangent or bitangent
//   zeroes all six components and reports the matching code.
module triangle_tangent_frame_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ttf_pkg::ttf_item_t   tri_word,
    output logic                 done,
    output ttf_pkg::ttf_result_t frame_word
);

    localparam int NS = ttf_pkg::NORM_STAGES;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] neg;     // index v*3+k; v=0 tangent, v=1 bitangent
    } side_t;

    // ---------------------------------------------------------------
    // stage 1: lane unpack and deltas
    // ---------------------------------------------------------------
    logic signed [16:0] d1_next [3];
    logic signed [16:0] d2_next [3];
    logic signed [16:0] du1_next, dv1_next, du2_next, dv2_next;

    logic signed [16:0] d1_reg [3];
    logic signed [16:0] d2_reg [3];
    logic signed [16:0] du1_reg, dv1_reg, du2_reg, dv2_reg;

    logic [8:0] vld_reg;     // valid for stages 1..9

    always_comb
    begin
        logic signed [16:0] pa, pb, pc;
        logic signed [16:0] ua, va, ub, vb, uc, vc;
        for (int k = 0; k < 3; k++)
        begin
            pa = ttf_pkg::lane_get(ttf_pkg::WORD_W'(tri_word.corner_a_position), k, 1'b1);
            pb = ttf_pkg::lane_get(ttf_pkg::WORD_W'(tri_word.corner_b_position), k, 1'b1);
            pc = ttf_pkg::lane_get(ttf_pkg::WORD_W'(tri_word.corner_c_position), k, 1'b1);
            d1_next[k] = pb - pa;
            d2_next[k] = pc - pa;
        end
        ua = ttf_pkg::lane_get(ttf_pkg::WORD_W'(tri_word.corner_a_uv), 0, 1'b0);
        va = ttf_pkg::lane_get(ttf_pkg::WORD_W'(tri_word.corner_a_uv), 1, 1'b0);
        ub = ttf_pkg::lane_get(ttf_pkg::WORD_W'(tri_word.corner_b_uv), 0, 1'b0);
        vb = ttf_pkg::lane_get(ttf_pkg::WORD_W'(tri_word.corner_b_uv), 1, 1'b0);
        uc = ttf_pkg::lane_get(ttf_pkg::WORD_W'(tri_word.corner_c_uv), 0, 1'b0);
        vc = ttf_pkg::lane_get(ttf_pkg::WORD_W'(tri_word.corner_c_uv), 1, 1'b0);
        du1_next = ub - ua;
        dv1_next = vb - va;
        du2_next = uc - ua;
        dv2_next = vc - va;
    end

    always_ff @(posedge clk)
    begin
        d1_reg  <= d1_next;
        d2_reg  <= d2_next;
        du1_reg <= du1_next;
        dv1_reg <= dv1_next;
        du2_reg <= du2_next;
        dv2_reg <= dv2_next;
    end

    // ---------------------------------------------------------------
    // stage 2: products (17x17 signed)
    // ---------------------------------------------------------------
    logic signed [33:0] pdet_a_reg, pdet_b_reg;
    logic signed [33:0] pa_reg [2][3];   // minuend of each cross term
    logic signed [33:0] pb_reg [2][3];   // subtrahend

    always_ff @(posedge clk)
    begin
        pdet_a_reg <= du1_reg * dv2_reg;
        pdet_b_reg <= dv1_reg * du2_reg;
        for (int k = 0; k < 3; k++)
        begin
            pa_reg[0][k] <= dv2_reg * d1_reg[k];
            pb_reg[0][k] <= dv1_reg * d2_reg[k];
            pa_reg[1][k] <= du1_reg * d2_reg[k];
            pb_reg[1][k] <= du2_reg * d1_reg[k];
        end
    end

    // ---------------------------------------------------------------
    // stage 3: determinant, tangent, bitangent
    // ---------------------------------------------------------------
    logic signed [34:0] det_reg;
    logic signed [34:0] vec_reg [2][3];

    always_ff @(posedge clk)
    begin
        det_reg <= 35'(pdet_a_reg) - 35'(pdet_b_reg);
        for (int v = 0; v < 2; v++)
            for (int k = 0; k < 3; k++)
                vec_reg[v][k] <= 35'(pa_reg[v][k]) - 35'(pb_reg[v][k]);
    end

    // ---------------------------------------------------------------
    // stage 4: magnitudes, signs (det sign folded in), status
    // ---------------------------------------------------------------
    logic [33:0] mag_next [2][3];
    side_t       side4_next;
    logic [33:0] mag4_reg [2][3];
    side_t       side4_reg;

    always_comb
    begin
        logic [1:0] zero;
        zero = 2'b00;
        side4_next.neg = '0;
        for (int v = 0; v < 2; v++)
        begin
            zero[v] = (vec_reg[v][0] == '0) && (vec_reg[v][1] == '0) && (vec_reg[v][2] == '0);
            for (int k = 0; k < 3; k++)
            begin
                mag_next[v][k] = vec_reg[v][k][34] ? 34'(-vec_reg[v][k])
                                                   : 34'(vec_reg[v][k]);
                side4_next.neg[v*3+k] = vec_reg[v][k][34] ^ det_reg[34];
            end
        end
        if (det_reg == '0)
            side4_next.status = ttf_pkg::STATUS_ZERO_DET;
        else if (zero != 2'b00)
            side4_next.status = ttf_pkg::STATUS_ZERO_LEN;
        else
            side4_next.status = ttf_pkg::STATUS_OK;
    end

    always_ff @(posedge clk)
    begin
        mag4_reg  <= mag_next;
        side4_reg <= side4_next;
    end

    // ---------------------------------------------------------------
    // stage 5: largest magnitude per vector
    // ---------------------------------------------------------------
    logic [33:0] top_next [2];
    logic [33:0] top_reg  [2];
    logic [33:0] mag5_reg [2][3];
    side_t       side5_reg;

    always_comb
    begin
        for (int v = 0; v < 2; v++)
        begin
            top_next[v] = mag4_reg[v][0];
            if (mag4_reg[v][1] > top_next[v])
                top_next[v] = mag4_reg[v][1];
            if (mag4_reg[v][2] > top_next[v])
                top_next[v] = mag4_reg[v][2];
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg   <= top_next;
        mag5_reg  <= mag4_reg;
        side5_reg <= side4_reg;
    end

    // ---------------------------------------------------------------
    // stage 6: shift that brings the largest below 2^16
    // ---------------------------------------------------------------
    logic [4:0]  sh_next [2];
    logic [4:0]  sh_reg  [2];
    logic [33:0] mag6_reg [2][3];
    side_t       side6_reg;

    always_comb
    begin
        logic [5:0] blen;
        for (int v = 0; v < 2; v++)
        begin
            blen = '0;
            for (int b = 0; b < 34; b++)
                if (top_reg[v][b])
                    blen = 6'(b + 1);
            sh_next[v] = (blen > 6'd16) ? 5'(blen - 6'd16) : 5'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        mag6_reg  <= mag5_reg;
        side6_reg <= side5_reg;
    end

    // ---------------------------------------------------------------
    // stage 7: scaled magnitudes
    // ---------------------------------------------------------------
    logic [15:0] m7_reg [2][3];
    side_t       side7_reg;

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < 2; v++)
            for (int k = 0; k < 3; k++)
                m7_reg[v][k] <= 16'(mag6_reg[v][k] >> sh_reg[v]);
        side7_reg <= side6_reg;
    end

    // ---------------------------------------------------------------
    // stage 8: squares
    // ---------------------------------------------------------------
    logic [31:0] sq8_reg [2][3];
    side_t       side8_reg;

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < 2; v++)
            for (int k = 0; k < 3; k++)
                sq8_reg[v][k] <= m7_reg[v][k] * m7_reg[v][k];
        side8_reg <= side7_reg;
    end

    // ---------------------------------------------------------------
    // stage 9: sum of squares
    // ---------------------------------------------------------------
    logic [31:0] sq9_reg [2][3];
    logic [33:0] s2_reg  [2];
    side_t       side9_reg;

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < 2; v++)
            s2_reg[v] <= 34'(sq8_reg[v][0]) + 34'(sq8_reg[v][1]) + 34'(sq8_reg[v][2]);
        sq9_reg   <= sq8_reg;
        side9_reg <= side8_reg;
    end

    // ---------------------------------------------------------------
    // normalizers, with sign/status and valid delayed to match
    // ---------------------------------------------------------------
    logic [14:0] root [2][3];

    for (genvar v = 0; v < 2; v++)
    begin : g_vec
        for (genvar k = 0; k < 3; k++)
        begin : g_comp
            ttf_norm u_norm (
                .clk  (clk),
                .sq   (sq9_reg[v][k]),
                .s2   (s2_reg[v]),
                .root (root[v][k])
            );
        end
    end

    side_t         side_dly_reg [NS];
    logic [NS-1:0] vld_dly_reg;

    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= side9_reg;
        for (int s = 1; s < NS; s++)
            side_dly_reg[s] <= side_dly_reg[s-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_dly_reg <= '0;
        end
        else
        begin
            vld_reg     <= {vld_reg[7:0], start & ~busy};
            vld_dly_reg <= {vld_dly_reg[NS-2:0], vld_reg[8]};
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    function automatic logic signed [15:0] signed_comp(input logic [14:0] r,
                                                       input logic        n,
                                                       input logic [1:0]  st);
        logic signed [15:0] p;
        p = $signed(16'(r));
        if (st != ttf_pkg::STATUS_OK)
            return '0;
        return n ? -p : p;
    endfunction

    side_t                side_out;
    ttf_pkg::ttf_result_t frame_next;
    ttf_pkg::ttf_result_t frame_reg;
    logic                 done_reg;

    assign side_out = side_dly_reg[NS-1];

    always_comb
    begin
        frame_next.tangent_x    = signed_comp(root[0][0], side_out.neg[0], side_out.status);
        frame_next.tangent_y    = signed_comp(root[0][1], side_out.neg[1], side_out.status);
        frame_next.tangent_z    = signed_comp(root[0][2], side_out.neg[2], side_out.status);
        frame_next.bitangent_x  = signed_comp(root[1][0], side_out.neg[3], side_out.status);
        frame_next.bitangent_y  = signed_comp(root[1][1], side_out.neg[4], side_out.status);
        frame_next.bitangent_z  = signed_comp(root[1][2], side_out.neg[5], side_out.status);
        frame_next.frame_status = side_out.status;
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_dly_reg[NS-1];
    end

    assign busy       = 1'b0;
    assign done       = done_reg;
    assign frame_word = frame_reg;

endmodule
